### src/pdvdm_pkg.sv
package pdvdm_pkg;

  // words per message: header plus up to six data objects
  localparam int MAX_DATA_OBJECTS = 7;
  localparam int POS_W = $clog2(MAX_DATA_OBJECTS + 1);

  localparam logic [15:0] SID_STANDARD     = 16'hff00;
  localparam logic [15:0] SVID_DISPLAYPORT = 16'hff01;
  localparam logic [15:0] SVID_UNSUPPORTED = 16'heeee;

  // pin assignment bit positions
  localparam int PIN_C = 2;
  localparam int PIN_D = 3;
  localparam int PIN_E = 4;

  typedef enum logic [0:0] {
    CFG_PLATFORM_PRESENT = 1'b0,
    CFG_MODAL_SUPPORTED  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    CMD_DISC_IDENT = 5'd1,
    CMD_DISC_SVID  = 5'd2,
    CMD_DISC_MODES = 5'd3,
    CMD_ENTER      = 5'd4,
    CMD_EXIT       = 5'd5,
    CMD_ATTENTION  = 5'd6,
    CMD_DP_STATUS  = 5'd16,
    CMD_DP_CONFIG  = 5'd17
  } vdm_cmd_t;

  typedef enum logic [1:0] {
    CT_REQ  = 2'd0,
    CT_ACK  = 2'd1,
    CT_NAK  = 2'd2,
    CT_BUSY = 2'd3
  } cmd_type_t;

  typedef enum logic [2:0] {
    ES_OTHER     = 3'd0,
    ES_DFP_IDENT = 3'd1,
    ES_SRC_IDENT = 3'd2,
    ES_SVIDS     = 3'd3,
    ES_MODES     = 3'd4,
    ES_ENTRY     = 3'd5,
    ES_STATUS    = 3'd6,
    ES_CONFIG    = 3'd7
  } engine_state_t;

  typedef enum logic [2:0] {
    RPL_NONE       = 3'd0,
    RPL_DI_ACK     = 3'd1,
    RPL_DI_NAK     = 3'd2,
    RPL_SVID_ACK   = 3'd3,
    RPL_SVID_NAK   = 3'd4,
    RPL_MODES_NAK  = 3'd5,
    RPL_ENTER_NAK  = 3'd6,
    RPL_EXIT_NAK   = 3'd7
  } reply_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSTRUCT    = 3'd1,
    ST_BAD_SVID    = 3'd2,
    ST_WRONG_STATE = 3'd3,
    ST_UNKNOWN_CMD = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ALT_NONE     = 3'd0,
    ALT_DI       = 3'd1,
    ALT_SVID     = 3'd2,
    ALT_MODES    = 3'd3,
    ALT_ENTERED  = 3'd4,
    ALT_STATUS   = 3'd5,
    ALT_SUCCESS  = 3'd6,
    ALT_FAIL     = 3'd7
  } mode_state_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ATTACHED = 2'd1,
    EV_DETACHED = 2'd2
  } dp_event_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        first_word;
    logic        last_word;
    logic [2:0]  engine_state;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  reply_action;
    logic [2:0]  status;
    logic [2:0]  mode_state;
    logic        go_ready;
    logic        go_wait_vbus;
    logic [15:0] reply_svid;
    logic [2:0]  reply_obj_pos;
    logic [2:0]  index_two_lane;
    logic [2:0]  index_four_lane;
    logic [5:0]  pin_assign_seen;
    logic [1:0]  dp_event;
    logic [1:0]  hpd_pulses;
  } out_word_t;

  // per-message scan results
  typedef struct packed {
    logic       vesa;
    logic [1:0] hpd_cap;   // bit0 hpd, bit1 irq_hpd
    logic [2:0] two;
    logic [2:0] four;
    logic [2:0] pins;      // {E, D, C}
  } scan_t;

endpackage

### src/pdvdm_scan.sv
module pdvdm_scan (
  input  logic                          en,
  input  logic [31:0]                   word,
  input  logic [pdvdm_pkg::POS_W-1:0]   pos,
  input  pdvdm_pkg::scan_t              cur,
  output pdvdm_pkg::scan_t              nxt
);

  logic [7:0] pins;
  logic       ufp_d;

  assign pins  = word[15:8] | word[23:16];
  assign ufp_d = word[0];

  always_comb begin
    nxt = cur;
    if (en) begin
      if (word[31:16] == pdvdm_pkg::SVID_DISPLAYPORT ||
          word[15:0] == pdvdm_pkg::SVID_DISPLAYPORT) begin
        nxt.vesa = 1'b1;
      end
      if (pos == pdvdm_pkg::POS_W'(1)) begin
        nxt.hpd_cap = {word[8], word[7]};
      end
      if (ufp_d) begin
        if (cur.four == 3'd0) begin
          if (pins[pdvdm_pkg::PIN_E]) begin
            nxt.four    = 3'(pos);
            nxt.pins[2] = 1'b1;
          end
          if (pins[pdvdm_pkg::PIN_C]) begin
            nxt.four    = 3'(pos);
            nxt.pins[0] = 1'b1;
          end
        end
        if (cur.two == 3'd0 && pins[pdvdm_pkg::PIN_D]) begin
          nxt.two     = 3'(pos);
          nxt.pins[1] = 1'b1;
        end
      end
    end
  end

endmodule

### src/pd_vdm_response_handler_core.sv
// Structured VDM responder with DisplayPort alt-mode discovery tracking. A received
// message enters one 32-bit word per cycle: the header (first_word) and then up to six
// data objects; last_word closes it. Words arriving with no message open are dropped
// silently. Each word is decoded combinationally and the state is updated at acceptance,
// so a word is taken every cycle while not stalled; the closing word yields one result
// word in the output register on the next cycle. Input stalls only while that output
// register is full and not being taken. Configuration writes are taken every cycle.
module pd_vdm_response_handler_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdvdm_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdvdm_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata
);

  logic                          plat_present_r, modal_sup_r;
  logic [31:0]                   header_r, header_nxt;
  logic [pdvdm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  pdvdm_pkg::scan_t              scan_r, scan_base, scan_nxt;
  logic                          scan_en;
  logic [2:0]                    disc_r, disc_nxt;
  logic [5:0]                    pin_r, pin_nxt;
  logic [2:0]                    two_r, two_nxt, four_r, four_nxt;
  logic                          phpd_r, phpd_nxt, lhpd_r, lhpd_nxt;
  logic                          out_valid_r;
  pdvdm_pkg::out_word_t          out_r, res;
  logic                          in_fire, res_gen;

  logic [15:0]          svid;
  logic [4:0]           cmd;
  logic [1:0]           ctype;
  logic [2:0]           es;
  logic                 hpd, irq;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign scan_base = in_data.first_word ? '0 : scan_r;
  assign scan_en   = !in_data.first_word && pos_r != '0 &&
                     pos_r < pdvdm_pkg::POS_W'(pdvdm_pkg::MAX_DATA_OBJECTS);
  assign res_gen   = in_data.last_word && (in_data.first_word || pos_r != '0);

  pdvdm_scan u_scan (
    .en   (scan_en),
    .word (in_data.data_word),
    .pos  (pos_r),
    .cur  (scan_base),
    .nxt  (scan_nxt)
  );

  always_comb begin
    header_nxt = in_data.first_word ? in_data.data_word : header_r;
    pos_nxt    = pos_r;
    if (in_data.first_word) begin
      pos_nxt = pdvdm_pkg::POS_W'(1);
    end else if (scan_en) begin
      pos_nxt = pos_r + pdvdm_pkg::POS_W'(1);
    end
    if (in_data.last_word) begin
      pos_nxt = '0;
    end
  end

  assign svid  = header_nxt[31:16];
  assign cmd   = header_nxt[4:0];
  assign ctype = header_nxt[7:6];
  assign es    = in_data.engine_state;
  assign hpd   = scan_nxt.hpd_cap[0];
  assign irq   = scan_nxt.hpd_cap[1];

  // message decode on the closing word
  always_comb begin
    disc_nxt = disc_r;
    pin_nxt  = pin_r;
    two_nxt  = two_r;
    four_nxt = four_r;
    phpd_nxt = phpd_r;
    lhpd_nxt = lhpd_r;
    res      = '0;
    if (!header_nxt[15]) begin
      res.status = pdvdm_pkg::ST_UNSTRUCT;
    end else begin
      unique case (cmd)
        pdvdm_pkg::CMD_DISC_IDENT, pdvdm_pkg::CMD_DISC_SVID: begin
          if (svid != pdvdm_pkg::SID_STANDARD) begin
            res.status = pdvdm_pkg::ST_BAD_SVID;
          end else if (ctype == pdvdm_pkg::CT_REQ) begin
            if (cmd == pdvdm_pkg::CMD_DISC_IDENT) begin
              res.reply_action = plat_present_r ? pdvdm_pkg::RPL_DI_ACK
                                                : pdvdm_pkg::RPL_DI_NAK;
            end else begin
              res.reply_action = modal_sup_r ? pdvdm_pkg::RPL_SVID_ACK
                                             : pdvdm_pkg::RPL_SVID_NAK;
            end
          end else if (cmd == pdvdm_pkg::CMD_DISC_IDENT &&
                       es != pdvdm_pkg::ES_DFP_IDENT && es != pdvdm_pkg::ES_SRC_IDENT) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else if (cmd == pdvdm_pkg::CMD_DISC_SVID && es != pdvdm_pkg::ES_SVIDS) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else if (cmd == pdvdm_pkg::CMD_DISC_IDENT && es == pdvdm_pkg::ES_SRC_IDENT) begin
            res.go_wait_vbus = 1'b1;
          end else begin
            if (cmd == pdvdm_pkg::CMD_DISC_IDENT) begin
              disc_nxt = (ctype == pdvdm_pkg::CT_ACK) ? pdvdm_pkg::ALT_DI :
                         (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL :
                                                        pdvdm_pkg::ALT_NONE;
            end else begin
              disc_nxt = (ctype == pdvdm_pkg::CT_ACK) ?
                           (scan_nxt.vesa ? pdvdm_pkg::ALT_SVID : pdvdm_pkg::ALT_FAIL) :
                         (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL :
                                                        pdvdm_pkg::ALT_DI;
            end
            res.go_ready = 1'b1;
          end
        end
        pdvdm_pkg::CMD_DISC_MODES: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            res.reply_action = pdvdm_pkg::RPL_MODES_NAK;
            res.reply_svid   = pdvdm_pkg::SVID_UNSUPPORTED;
          end else if (es != pdvdm_pkg::ES_MODES) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else begin
            if (ctype == pdvdm_pkg::CT_ACK) begin
              two_nxt  = scan_nxt.two;
              four_nxt = scan_nxt.four;
              pin_nxt  = pin_r | {1'b0, scan_nxt.pins, 2'b00};
              disc_nxt = (scan_nxt.two != '0 || scan_nxt.four != '0) ?
                         pdvdm_pkg::ALT_MODES : pdvdm_pkg::ALT_FAIL;
            end else begin
              disc_nxt = (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL
                                                      : pdvdm_pkg::ALT_SVID;
            end
            res.go_ready = 1'b1;
          end
        end
        pdvdm_pkg::CMD_ENTER: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            res.reply_action  = pdvdm_pkg::RPL_ENTER_NAK;
            res.reply_svid    = svid;
            res.reply_obj_pos = header_nxt[10:8];
          end else if (es != pdvdm_pkg::ES_ENTRY) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else begin
            disc_nxt = (ctype == pdvdm_pkg::CT_ACK) ? pdvdm_pkg::ALT_ENTERED :
                       (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL :
                                                      pdvdm_pkg::ALT_MODES;
            res.go_ready = 1'b1;
          end
        end
        pdvdm_pkg::CMD_EXIT: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            res.reply_action  = pdvdm_pkg::RPL_EXIT_NAK;
            res.reply_svid    = svid;
            res.reply_obj_pos = header_nxt[10:8];
          end
        end
        pdvdm_pkg::CMD_DP_STATUS: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            res.status = pdvdm_pkg::ST_OK;
          end else if (es != pdvdm_pkg::ES_STATUS) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else begin
            if (ctype == pdvdm_pkg::CT_ACK) begin
              phpd_nxt = hpd;
            end
            disc_nxt = (ctype == pdvdm_pkg::CT_ACK) ? pdvdm_pkg::ALT_STATUS :
                       (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL :
                                                      pdvdm_pkg::ALT_ENTERED;
            res.go_ready = 1'b1;
          end
        end
        pdvdm_pkg::CMD_DP_CONFIG: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            res.status = pdvdm_pkg::ST_OK;
          end else if (es != pdvdm_pkg::ES_CONFIG) begin
            res.status = pdvdm_pkg::ST_WRONG_STATE;
          end else begin
            if (ctype == pdvdm_pkg::CT_ACK) begin
              lhpd_nxt     = 1'b1;
              res.dp_event = pdvdm_pkg::EV_ATTACHED;
            end
            disc_nxt = (ctype == pdvdm_pkg::CT_ACK) ? pdvdm_pkg::ALT_SUCCESS :
                       (ctype == pdvdm_pkg::CT_NAK) ? pdvdm_pkg::ALT_FAIL :
                                                      pdvdm_pkg::ALT_STATUS;
            res.go_ready = 1'b1;
          end
        end
        pdvdm_pkg::CMD_ATTENTION: begin
          if (ctype == pdvdm_pkg::CT_REQ) begin
            if (phpd_r != hpd) begin
              phpd_nxt = hpd;
              if (lhpd_r != hpd) begin
                lhpd_nxt     = hpd;
                res.dp_event = hpd ? pdvdm_pkg::EV_ATTACHED : pdvdm_pkg::EV_DETACHED;
              end else if (lhpd_r) begin
                res.hpd_pulses = res.hpd_pulses + 2'd1;
              end
            end
            if (irq && lhpd_nxt) begin
              res.hpd_pulses = res.hpd_pulses + 2'd1;
            end
          end
        end
        default: begin
          res.status = pdvdm_pkg::ST_UNKNOWN_CMD;
        end
      endcase
    end
    res.mode_state      = disc_nxt;
    res.index_two_lane  = two_nxt;
    res.index_four_lane = four_nxt;
    res.pin_assign_seen = pin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plat_present_r <= 1'b0;
      modal_sup_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdvdm_pkg::CFG_PLATFORM_PRESENT: plat_present_r <= cfg_wdata;
        pdvdm_pkg::CFG_MODAL_SUPPORTED:  modal_sup_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      pos_r    <= '0;
      scan_r   <= '0;
      disc_r   <= '0;
      pin_r    <= '0;
      two_r    <= '0;
      four_r   <= '0;
      phpd_r   <= 1'b0;
      lhpd_r   <= 1'b0;
    end else if (in_fire) begin
      header_r <= header_nxt;
      pos_r    <= pos_nxt;
      scan_r   <= scan_nxt;
      if (res_gen) begin
        disc_r <= disc_nxt;
        pin_r  <= pin_nxt;
        two_r  <= two_nxt;
        four_r <= four_nxt;
        phpd_r <= phpd_nxt;
        lhpd_r <= lhpd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_gen) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_gen) begin
      out_r <= res;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= pdvdm_pkg::POS_W'(pdvdm_pkg::MAX_DATA_OBJECTS))
    else $error("word position beyond message length");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_word |=> pos_r == '0)
    else $error("message still open after last word");

  a_vbus_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.go_wait_vbus |-> !out_data.go_ready)
    else $error("wait-vbus and ready moves together");

  a_svid_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_svid != '0 |->
      out_data.reply_action == pdvdm_pkg::RPL_MODES_NAK ||
      out_data.reply_action == pdvdm_pkg::RPL_ENTER_NAK ||
      out_data.reply_action == pdvdm_pkg::RPL_EXIT_NAK)
    else $error("svid echoed without a nack reply");

  a_stray_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.first_word && pos_r == '0 |=> pos_r == '0)
    else $error("stray word opened a message");

endmodule

### verif/tb_pd_vdm_response_handler_core.sv
module tb_pd_vdm_response_handler_core;
  import pdvdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int WORDS_PER_PHASE = 290;
  localparam logic [4:0] CMD_RESERVED = 5'h1f;

  typedef enum int {VDO_RAW, VDO_SVID, VDO_MODE, VDO_STATUS, VDO_MIXED} vdo_kind_t;

  // tracks discovery state and predicts the reply word for each closed message
  class vdm_reply_tracker;
    logic platform_present = 1'b0;
    logic modal_ok = 1'b0;
    logic [31:0] hdr = '0;
    logic [2:0] wpos = '0;
    mode_state_t disc = ALT_NONE;
    logic [5:0] pins = '0;
    logic [2:0] two = '0;
    logic [2:0] four = '0;
    logic vesa = 1'b0;
    logic partner_hpd = 1'b0;
    logic local_hpd = 1'b0;
    logic [1:0] hpd_cap = '0;
    logic [2:0] sc_two = '0;
    logic [2:0] sc_four = '0;
    logic [5:0] sc_pins = '0;
    out_word_t owed_replies[$];
    int n_taken = 0;
    int n_results = 0;
    int n_errors = 0;

    function void write_reg(logic idx, logic v);
      if (idx == CFG_PLATFORM_PRESENT) platform_present = v;
      else modal_ok = v;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    function void scan_word(logic [31:0] w, logic [2:0] k);
      logic [7:0] pf;
      pf = w[15:8] | w[23:16];
      if (w[31:16] == SVID_DISPLAYPORT || w[15:0] == SVID_DISPLAYPORT) vesa = 1'b1;
      if (k == 3'd1) hpd_cap = {w[8], w[7]};
      // only ufp_d capable modes (capability bit 0 set) count
      if (!w[0]) return;
      if (sc_four == 0) begin
        if (pf[PIN_E]) begin
          sc_four = k;
          sc_pins[PIN_E] = 1'b1;
        end
        if (pf[PIN_C]) begin
          sc_four = k;
          sc_pins[PIN_C] = 1'b1;
        end
      end
      if (sc_two == 0 && pf[PIN_D]) begin
        sc_two = k;
        sc_pins[PIN_D] = 1'b1;
      end
    endfunction

    function void note_word(in_word_t x);
      out_word_t r;
      logic [15:0] svid;
      logic [4:0] cmd;
      cmd_type_t ct;
      engine_state_t es;
      logic hpd, irq;
      if (x.first_word) begin
        hdr = x.data_word;
        wpos = 3'd1;
        vesa = 1'b0;
        hpd_cap = '0;
        sc_two = '0;
        sc_four = '0;
        sc_pins = '0;
      end else if (wpos == 0) begin
        return;
      end else if (wpos < MAX_DATA_OBJECTS) begin
        scan_word(x.data_word, wpos);
        wpos = wpos + 3'd1;
      end
      n_taken++;
      if (!x.last_word) return;
      wpos = '0;

      r = '0;
      svid = hdr[31:16];
      cmd = hdr[4:0];
      ct = cmd_type_t'(hdr[7:6]);
      es = engine_state_t'(x.engine_state);
      if (!hdr[15]) begin
        r.status = ST_UNSTRUCT;
      end else begin
        case (cmd)
          CMD_DISC_IDENT, CMD_DISC_SVID: begin
            if (svid != SID_STANDARD) r.status = ST_BAD_SVID;
            else if (ct == CT_REQ) begin
              if (cmd == CMD_DISC_IDENT) r.reply_action = platform_present ? RPL_DI_ACK : RPL_DI_NAK;
              else r.reply_action = modal_ok ? RPL_SVID_ACK : RPL_SVID_NAK;
            end else if (cmd == CMD_DISC_IDENT && es != ES_DFP_IDENT && es != ES_SRC_IDENT)
              r.status = ST_WRONG_STATE;
            else if (cmd == CMD_DISC_SVID && es != ES_SVIDS) r.status = ST_WRONG_STATE;
            else if (cmd == CMD_DISC_IDENT && es == ES_SRC_IDENT) r.go_wait_vbus = 1'b1;
            else begin
              if (cmd == CMD_DISC_IDENT)
                disc = (ct == CT_ACK) ? ALT_DI : (ct == CT_NAK) ? ALT_FAIL : ALT_NONE;
              else
                disc = (ct == CT_ACK) ? (vesa ? ALT_SVID : ALT_FAIL) :
                       (ct == CT_NAK) ? ALT_FAIL : ALT_DI;
              r.go_ready = 1'b1;
            end
          end
          CMD_DISC_MODES: begin
            if (ct == CT_REQ) begin
              r.reply_action = RPL_MODES_NAK;
              r.reply_svid = SVID_UNSUPPORTED;
            end else if (es != ES_MODES) r.status = ST_WRONG_STATE;
            else begin
              if (ct == CT_ACK) begin
                two = sc_two;
                four = sc_four;
                pins = pins | sc_pins;
                disc = (sc_two != 0 || sc_four != 0) ? ALT_MODES : ALT_FAIL;
              end else disc = (ct == CT_NAK) ? ALT_FAIL : ALT_SVID;
              r.go_ready = 1'b1;
            end
          end
          CMD_ENTER: begin
            if (ct == CT_REQ) begin
              r.reply_action = RPL_ENTER_NAK;
              r.reply_svid = svid;
              r.reply_obj_pos = hdr[10:8];
            end else if (es != ES_ENTRY) r.status = ST_WRONG_STATE;
            else begin
              disc = (ct == CT_ACK) ? ALT_ENTERED : (ct == CT_NAK) ? ALT_FAIL : ALT_MODES;
              r.go_ready = 1'b1;
            end
          end
          CMD_EXIT: begin
            if (ct == CT_REQ) begin
              r.reply_action = RPL_EXIT_NAK;
              r.reply_svid = svid;
              r.reply_obj_pos = hdr[10:8];
            end
          end
          CMD_DP_STATUS, CMD_DP_CONFIG: begin
            if (ct == CT_REQ) begin
              // partner request: nothing to send
            end else if (es != ((cmd == CMD_DP_STATUS) ? ES_STATUS : ES_CONFIG))
              r.status = ST_WRONG_STATE;
            else begin
              if (cmd == CMD_DP_STATUS) begin
                if (ct == CT_ACK) partner_hpd = hpd_cap[0];
                disc = (ct == CT_ACK) ? ALT_STATUS : (ct == CT_NAK) ? ALT_FAIL : ALT_ENTERED;
              end else begin
                if (ct == CT_ACK) begin
                  local_hpd = 1'b1;
                  r.dp_event = EV_ATTACHED;
                end
                disc = (ct == CT_ACK) ? ALT_SUCCESS : (ct == CT_NAK) ? ALT_FAIL : ALT_STATUS;
              end
              r.go_ready = 1'b1;
            end
          end
          CMD_ATTENTION: begin
            if (ct == CT_REQ) begin
              hpd = hpd_cap[0];
              irq = hpd_cap[1];
              if (partner_hpd != hpd) begin
                partner_hpd = hpd;
                if (local_hpd != hpd) begin
                  local_hpd = hpd;
                  r.dp_event = hpd ? EV_ATTACHED : EV_DETACHED;
                end else if (local_hpd) r.hpd_pulses = r.hpd_pulses + 2'd1;
              end
              if (irq && local_hpd) r.hpd_pulses = r.hpd_pulses + 2'd1;
            end
          end
          default: r.status = ST_UNKNOWN_CMD;
        endcase
      end
      r.mode_state = disc;
      r.index_two_lane = two;
      r.index_four_lane = four;
      r.pin_assign_seen = pins;
      owed_replies.push_back(r);
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_reply(out_word_t act);
      out_word_t want;
      if (owed_replies.size() == 0) begin
        n_errors++;
        $display("%0t: reply with none expected, expected nothing, actual %h", $time, act);
        return;
      end
      want = owed_replies.pop_front();
      n_results++;
      cmp("reply_action", 32'(want.reply_action), 32'(act.reply_action));
      cmp("status", 32'(want.status), 32'(act.status));
      cmp("mode_state", 32'(want.mode_state), 32'(act.mode_state));
      cmp("go_ready", 32'(want.go_ready), 32'(act.go_ready));
      cmp("go_wait_vbus", 32'(want.go_wait_vbus), 32'(act.go_wait_vbus));
      cmp("reply_svid", 32'(want.reply_svid), 32'(act.reply_svid));
      cmp("reply_obj_pos", 32'(want.reply_obj_pos), 32'(act.reply_obj_pos));
      cmp("index_two_lane", 32'(want.index_two_lane), 32'(act.index_two_lane));
      cmp("index_four_lane", 32'(want.index_four_lane), 32'(act.index_four_lane));
      cmp("pin_assign_seen", 32'(want.pin_assign_seen), 32'(act.pin_assign_seen));
      cmp("dp_event", 32'(want.dp_event), 32'(act.dp_event));
      cmp("hpd_pulses", 32'(want.hpd_pulses), 32'(act.hpd_pulses));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic cfg_wdata;

  vdm_reply_tracker sb;
  logic [31:0] payload[$];
  int burst_left = 0;
  int rx_mode = 0;
  int rx_span = 0;
  int idle_cycles = 0;
  int n_flows = 0;
  int n_settings = 0;

  pd_vdm_response_handler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_reply(out_data);
    end
  end

  // receiver: switches between always ready, coin flips, sparse and square-wave stalls
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_span <= $urandom_range(20, 150);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_span[4];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t mk_word(logic [31:0] d, logic f, logic l, engine_state_t es);
    in_word_t x;
    x.data_word = d;
    x.first_word = f;
    x.last_word = l;
    // engine state only matters on the closing word
    x.engine_state = l ? es : 3'($urandom);
    return x;
  endfunction

  function automatic logic [31:0] vdm_hdr(logic [15:0] svid, logic structured,
                                           logic [2:0] pos, logic [1:0] ct, logic [4:0] cmd);
    logic [31:0] h;
    h = $urandom;
    h[31:16] = svid;
    h[15] = structured;
    h[10:8] = pos;
    h[7:6] = ct;
    h[4:0] = cmd;
    return h;
  endfunction

  function automatic logic [7:0] pin_byte();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(0, 3))
      0: b = '0;
      1: b = 8'd1 << $urandom_range(PIN_C, PIN_E);
      2: b = b & 8'h1c;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] gen_vdo(vdo_kind_t kind);
    logic [31:0] w;
    vdo_kind_t k;
    k = (kind == VDO_MIXED) ? vdo_kind_t'($urandom_range(VDO_RAW, VDO_STATUS)) : kind;
    w = $urandom;
    case (k)
      VDO_SVID: begin
        if ($urandom_range(0, 4) < 2) w[31:16] = SVID_DISPLAYPORT;
        if ($urandom_range(0, 4) < 2) w[15:0] = SVID_DISPLAYPORT;
      end
      VDO_MODE: begin
        w[15:8] = pin_byte();
        w[23:16] = pin_byte();
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic engine_state_t natural_state(logic [4:0] cmd);
    case (cmd)
      CMD_DISC_IDENT: return ($urandom_range(0, 3) == 0) ? ES_SRC_IDENT : ES_DFP_IDENT;
      CMD_DISC_SVID:  return ES_SVIDS;
      CMD_DISC_MODES: return ES_MODES;
      CMD_ENTER:      return ES_ENTRY;
      CMD_DP_STATUS:  return ES_STATUS;
      CMD_DP_CONFIG:  return ES_CONFIG;
      default:        return engine_state_t'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic cmd_type_t flow_ct();
    return ($urandom_range(0, 9) < 8) ? CT_ACK : cmd_type_t'($urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] pick_svid();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return SID_STANDARD;
    if (r < 17) return SVID_DISPLAYPORT;
    return 16'($urandom);
  endfunction

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // header plus the words in payload; close=0 leaves the message open
  task automatic send_msg(logic [31:0] h, engine_state_t es, logic close);
    int n;
    n = payload.size();
    send_word(mk_word(h, 1'b1, close && n == 0, es));
    foreach (payload[i]) send_word(mk_word(payload[i], 1'b0, close && i == n - 1, es));
  endtask

  task automatic fill_payload(int n, vdo_kind_t kind);
    payload.delete();
    repeat (n) payload.push_back(gen_vdo(kind));
  endtask

  task automatic send_cmd(logic [4:0] cmd, logic [15:0] svid, cmd_type_t ct, engine_state_t es,
                          vdo_kind_t kind, int n);
    fill_payload(n, kind);
    send_msg(vdm_hdr(svid, 1'b1, 3'($urandom), ct, cmd), es, 1'b1);
  endtask

  task automatic run_flow();
    send_cmd(CMD_DISC_IDENT, SID_STANDARD, flow_ct(), natural_state(CMD_DISC_IDENT), VDO_RAW,
             $urandom_range(0, 4));
    send_cmd(CMD_DISC_SVID, SID_STANDARD, flow_ct(), ES_SVIDS, VDO_SVID, $urandom_range(1, 6));
    send_cmd(CMD_DISC_MODES, SVID_DISPLAYPORT, flow_ct(), ES_MODES, VDO_MODE,
             $urandom_range(1, 6));
    send_cmd(CMD_ENTER, SVID_DISPLAYPORT, flow_ct(), ES_ENTRY, VDO_RAW, 0);
    send_cmd(CMD_DP_STATUS, SVID_DISPLAYPORT, flow_ct(), ES_STATUS, VDO_STATUS, 1);
    send_cmd(CMD_DP_CONFIG, SVID_DISPLAYPORT, flow_ct(), ES_CONFIG, VDO_RAW, 1);
    repeat ($urandom_range(0, 3))
      send_cmd(CMD_ATTENTION, SVID_DISPLAYPORT, CT_REQ, engine_state_t'($urandom_range(0, 7)),
               VDO_STATUS, 1);
    n_flows++;
  endtask

  task automatic send_random_msg(logic close);
    logic [4:0] cmd;
    engine_state_t es;
    vdo_kind_t kind;
    int n;
    case ($urandom_range(0, 9))
      0: cmd = CMD_DISC_IDENT;
      1: cmd = CMD_DISC_SVID;
      2: cmd = CMD_DISC_MODES;
      3: cmd = CMD_ENTER;
      4: cmd = CMD_EXIT;
      5: cmd = CMD_ATTENTION;
      6: cmd = CMD_DP_STATUS;
      7: cmd = CMD_DP_CONFIG;
      default: cmd = 5'($urandom);
    endcase
    case (cmd)
      CMD_DISC_SVID: kind = VDO_SVID;
      CMD_DISC_MODES: kind = VDO_MODE;
      CMD_ATTENTION, CMD_DP_STATUS: kind = VDO_STATUS;
      default: kind = VDO_MIXED;
    endcase
    es = ($urandom_range(0, 4) == 0) ? engine_state_t'($urandom_range(0, 7)) : natural_state(cmd);
    // now and then more words than the block scans
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
    fill_payload(n, kind);
    send_msg(vdm_hdr(pick_svid(), $urandom_range(0, 19) != 0, 3'($urandom),
                     2'($urandom_range(0, 3)), cmd), es, close);
  endtask

  task automatic write_settings(logic platform, logic modal);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PLATFORM_PRESENT;
    cfg_wdata <= platform;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MODAL_SUPPORTED;
    cfg_wdata <= modal;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int goal;
    int r;
    logic platform, modal;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PLATFORM_PRESENT;
    cfg_wdata <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_settings(1'b0, 1'b1);

    // stray word with no message open, then an all-zero (unstructured) header
    send_word(mk_word('1, 1'b0, 1'b1, ES_CONFIG));
    payload.delete();
    send_msg('0, ES_OTHER, 1'b1);
    send_cmd(CMD_DISC_IDENT, SID_STANDARD, CT_REQ, ES_OTHER, VDO_RAW, 0);
    send_cmd(CMD_DISC_SVID, SID_STANDARD, CT_REQ, ES_OTHER, VDO_RAW, 0);
    send_cmd(CMD_DISC_IDENT, SVID_DISPLAYPORT, CT_ACK, ES_DFP_IDENT, VDO_RAW, 0);
    send_cmd(CMD_DISC_IDENT, SID_STANDARD, CT_ACK, ES_OTHER, VDO_RAW, 0);
    send_cmd(CMD_DISC_IDENT, SID_STANDARD, CT_ACK, ES_SRC_IDENT, VDO_RAW, 0);
    send_cmd(CMD_DISC_IDENT, SID_STANDARD, CT_ACK, ES_DFP_IDENT, VDO_RAW, 0);
    payload.delete();
    payload.push_back({16'h0000, SVID_DISPLAYPORT});
    send_msg(vdm_hdr(SID_STANDARD, 1'b1, 3'd0, CT_ACK, CMD_DISC_SVID), ES_SVIDS, 1'b1);
    send_cmd(CMD_DISC_MODES, SVID_DISPLAYPORT, CT_REQ, ES_OTHER, VDO_RAW, 0);
    // mode offering pins c, d and e with ufp_d capability
    payload.delete();
    payload.push_back(32'h001c_1c05);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_ACK, CMD_DISC_MODES), ES_MODES, 1'b1);
    payload.delete();
    send_msg(vdm_hdr(16'hffff, 1'b1, 3'd7, CT_REQ, CMD_ENTER), ES_OTHER, 1'b1);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_REQ, CMD_EXIT), ES_OTHER, 1'b1);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_ACK, CMD_ENTER), ES_ENTRY, 1'b1);
    payload.push_back(32'h0000_0080);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_ACK, CMD_DP_STATUS), ES_STATUS, 1'b1);
    payload.delete();
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_ACK, CMD_DP_CONFIG), ES_CONFIG, 1'b1);
    // hpd still high plus irq: one short pulse
    payload.push_back(32'h0000_0180);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd1, CT_REQ, CMD_ATTENTION), ES_OTHER, 1'b1);
    payload.delete();
    send_msg(vdm_hdr(SID_STANDARD, 1'b1, 3'd0, CT_REQ, CMD_RESERVED), ES_OTHER, 1'b1);
    // header arriving inside an open message
    payload.push_back('1);
    send_msg(vdm_hdr(SVID_DISPLAYPORT, 1'b1, 3'd0, CT_ACK, CMD_DISC_MODES), ES_MODES, 1'b0);
    send_cmd(CMD_ENTER, SVID_DISPLAYPORT, CT_BUSY, ES_ENTRY, VDO_RAW, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin platform = 1'b0; modal = 1'b0; end
        1: begin platform = 1'b1; modal = 1'b1; end
        2: begin platform = 1'b1; modal = 1'b0; end
        3: begin platform = 1'b0; modal = 1'b1; end
        default: begin
          platform = 1'($urandom_range(0, 1));
          modal = 1'($urandom_range(0, 1));
        end
      endcase
      drain_results();
      write_settings(platform, modal);
      goal = sb.n_taken + WORDS_PER_PHASE;
      while (sb.n_taken < goal) begin
        r = $urandom_range(0, 99);
        if (r < 15) run_flow();
        else if (r < 85) send_random_msg(1'b1);
        else if (r < 93) begin
          repeat ($urandom_range(1, 3))
            send_word(mk_word($urandom, 1'b0, 1'($urandom_range(0, 1)),
                              engine_state_t'($urandom_range(0, 7))));
        end else send_random_msg(1'b0);
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d decoded words, %0d checked replies, %0d alt-mode flows, %0d settings",
             sb.n_taken, sb.n_results, n_flows, n_settings);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
